// ----- src/dual_row_hex_seven_segment_scanner_macros.svh -----
// Assertion macros for the dual-row seven-segment scanner.
// Used at the end of the top level; depends on nothing.
`ifndef DUAL_ROW_HEX_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define DUAL_ROW_HEX_SEVEN_SEGMENT_SCANNER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DR7S_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dr7s: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DR7S_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dr7s: next-cycle check failed");

`endif

// ----- src/dr7s_pkg.sv -----
// Shared types, constants and the segment decoder for the scanner.
// No dependencies.
`default_nettype none
package dr7s_pkg;
	localparam logic [1:0] PH_UPPER = 2'd0;
	localparam logic [1:0] PH_LOWER = 2'd1;
	localparam logic [1:0] PH_BLANK = 2'd2;

	localparam logic [7:0] UPPER_FIRST_MASK = 8'h80;
	localparam logic [7:0] LOWER_FIRST_MASK = 8'h08;

	localparam int PAIRS_PER_TICK = 16;
	localparam int PAIR_CNT_W     = $clog2(PAIRS_PER_TICK);

	// One tick's worth of serial data: segments then column mask, MSB first.
	typedef struct packed {
		logic [PAIRS_PER_TICK-1:0] word0;
		logic [PAIRS_PER_TICK-1:0] word1;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} q_push_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} q_head_t;

	// Active-low hex segment pattern.
	function automatic logic [7:0] seg_pattern(input logic [3:0] nib);
		logic [7:0] s;
		case (nib)
			4'h0: s = 8'hC0;
			4'h1: s = 8'hF9;
			4'h2: s = 8'hA4;
			4'h3: s = 8'hB0;
			4'h4: s = 8'h99;
			4'h5: s = 8'h92;
			4'h6: s = 8'h82;
			4'h7: s = 8'hF8;
			4'h8: s = 8'h80;
			4'h9: s = 8'h90;
			4'hA: s = 8'h88;
			4'hB: s = 8'h83;
			4'hC: s = 8'hC6;
			4'hD: s = 8'hA1;
			4'hE: s = 8'h86;
			4'hF: s = 8'h8E;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction
endpackage
`default_nettype wire

// ----- src/dr7s_in_if.sv -----
// Input channel: valid/ready handshake carrying an op and two row values.
// Depends on nothing.
`default_nettype none
interface dr7s_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] new_row0;
	logic [31:0] new_row1;

	modport source (output valid, output op, output new_row0, output new_row1, input ready);
	modport sink   (input valid, input op, input new_row0, input new_row1, output ready);
endinterface
`default_nettype wire

// ----- src/dr7s_out_if.sv -----
// Output channel: valid/ready handshake carrying one serial bit pair.
// Depends on nothing.
`default_nettype none
interface dr7s_out_if;
	logic valid;
	logic ready;
	logic line0_bit;
	logic line1_bit;
	logic latch_after;

	modport source (output valid, output line0_bit, output line1_bit, output latch_after,
		input ready);
	modport sink   (input valid, input line0_bit, input line1_bit, input latch_after,
		output ready);
endinterface
`default_nettype wire

// ----- src/dual_row_hex_seven_segment_scanner.sv -----
// Top level of the dual-row hex seven-segment scanner: front end, job queue, serializer.
// Depends on dr7s_pkg, dr7s_in_if, dr7s_out_if, the macros header and the submodules.
//
//   channel | dir | payload                                | handshake
//   in_ch   | in  | op, new_row0[31:0], new_row1[31:0]     | valid/ready
//   out_ch  | out | line0_bit, line1_bit, latch_after      | valid/ready
//
// A tick is shifted out by the serializer as sixteen bit pairs, one bit pair per cycle while out_ch is ready.
// A set item only updates the held rows and gives no output.
// The two-entry queue lets the front end take up to two ticks ahead of the serializer.
// in_ch.ready drops only while the queue is full; a stalled out_ch holds the current pair.
// Reset clears the scan to the first upper digit with all rows at zero.
`default_nettype none
`include "dual_row_hex_seven_segment_scanner_macros.svh"
module dual_row_hex_seven_segment_scanner import dr7s_pkg::*; #(
	parameter int DIGITS_PER_HALF = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dr7s_in_if.sink    in_ch,
	dr7s_out_if.source out_ch
);
	q_push_t push;
	q_head_t head;
	logic    q_full, pop;

	dr7s_front #(.DIGITS_PER_HALF(DIGITS_PER_HALF)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push)
	);

	dr7s_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	dr7s_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	`DR7S_ASSERT_IMP(a_set_no_job, clk, arst_n, in_ch.valid && in_ch.ready && in_ch.op, !push.push)
	`DR7S_ASSERT_IMP(a_tick_job, clk, arst_n, in_ch.valid && in_ch.ready && !in_ch.op, push.push)
	`DR7S_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, head.valid)
	`DR7S_ASSERT_NXT(a_idle_after_latch, clk, arst_n,
		out_ch.valid && out_ch.ready && out_ch.latch_after && !head.valid, !out_ch.valid)
endmodule
`default_nettype wire

// ----- src/dr7s_front.sv -----
// Front end: accepts items, keeps the held rows and scan position, builds shift jobs.
// Depends on dr7s_pkg and dr7s_in_if.
`default_nettype none
module dr7s_front import dr7s_pkg::*; #(
	parameter int DIGITS_PER_HALF = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dr7s_in_if.sink     in_ch,
	input  wire logic   q_full,
	output q_push_t     push
);
	logic [1:0]  phase_q;
	logic [2:0]  count_q;
	logic [7:0]  mask_q;
	logic [15:0] nib0_q, nib1_q;
	logic [31:0] held0_q, held1_q;

	logic       xfer, tick;
	logic [3:0] count_inc;
	logic       half_done;

	assign in_ch.ready = !q_full;
	assign xfer        = in_ch.valid && in_ch.ready;
	assign tick        = xfer && !in_ch.op;
	assign count_inc   = {1'b0, count_q} + 4'd1;
	assign half_done   = count_inc >= 4'(DIGITS_PER_HALF);

	always_comb begin
		push.push = tick;
		if (phase_q == PH_UPPER || phase_q == PH_LOWER) begin
			push.job.word0 = {seg_pattern(nib0_q[3:0]), mask_q};
			push.job.word1 = {seg_pattern(nib1_q[3:0]), mask_q};
		end else begin
			push.job = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UPPER;
			count_q <= '0;
			mask_q  <= UPPER_FIRST_MASK;
			nib0_q  <= '0;
			nib1_q  <= '0;
			held0_q <= '0;
			held1_q <= '0;
		end else if (xfer && in_ch.op) begin
			held0_q <= in_ch.new_row0;
			held1_q <= in_ch.new_row1;
		end else if (tick) begin
			case (phase_q)
				PH_UPPER: begin
					if (half_done) begin
						mask_q  <= LOWER_FIRST_MASK;
						nib0_q  <= held0_q[15:0];
						nib1_q  <= held1_q[15:0];
						count_q <= '0;
						phase_q <= PH_LOWER;
					end else begin
						mask_q  <= mask_q >> 1;
						nib0_q  <= nib0_q >> 4;
						nib1_q  <= nib1_q >> 4;
						count_q <= count_inc[2:0];
					end
				end
				PH_LOWER: begin
					mask_q  <= mask_q >> 1;
					nib0_q  <= nib0_q >> 4;
					nib1_q  <= nib1_q >> 4;
					count_q <= count_inc[2:0];
					if (half_done)
						phase_q <= PH_BLANK;
				end
				default: begin
					// blanking tick: reload the upper halves
					mask_q  <= UPPER_FIRST_MASK;
					nib0_q  <= held0_q[31:16];
					nib1_q  <= held1_q[31:16];
					count_q <= '0;
					phase_q <= PH_UPPER;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/dr7s_queue.sv -----
// Two-entry job queue between the front end and the serializer.
// Depends on dr7s_pkg.
`default_nettype none
module dr7s_queue import dr7s_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  q_push_t   push,
	input  wire logic pop,
	output logic      full,
	output q_head_t   head
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push)
			slot_q[wr_ptr_q] <= push.job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push.push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/dr7s_back.sv -----
// Serializer: shifts each job out as sixteen bit pairs, flagging the last one.
// Depends on dr7s_pkg and dr7s_out_if.
`default_nettype none
module dr7s_back import dr7s_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  q_head_t    head,
	output logic       pop,
	dr7s_out_if.source out_ch
);
	logic [PAIRS_PER_TICK-1:0] sh0_q, sh1_q;
	logic [PAIR_CNT_W-1:0]     cnt_q;
	logic                      busy_q;
	logic                      last, xfer;

	assign last   = cnt_q == PAIR_CNT_W'(PAIRS_PER_TICK - 1);
	assign xfer   = busy_q && out_ch.ready;
	assign pop    = head.valid && (!busy_q || (xfer && last));

	assign out_ch.valid       = busy_q;
	assign out_ch.line0_bit   = sh0_q[PAIRS_PER_TICK-1];
	assign out_ch.line1_bit   = sh1_q[PAIRS_PER_TICK-1];
	assign out_ch.latch_after = last;

	always_ff @(posedge clk) begin
		if (pop) begin
			sh0_q <= head.job.word0;
			sh1_q <= head.job.word1;
		end else if (xfer) begin
			sh0_q <= sh0_q << 1;
			sh1_q <= sh1_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (xfer) begin
			// drop out of busy after the latch pair when nothing is queued
			if (last)
				busy_q <= 1'b0;
			cnt_q <= cnt_q + PAIR_CNT_W'(1);
		end
	end
endmodule
`default_nettype wire
